[hdl/joint_angle_accel_predictor_defines.svh]
// ----------------------------------------------------------------------------
// Joint angle acceleration predictor - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef JOINT_ANGLE_ACCEL_PREDICTOR_DEFINES_SVH
`define JOINT_ANGLE_ACCEL_PREDICTOR_DEFINES_SVH

// same-cycle implication
`define JAAP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JAAP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/jaap_pkg.sv]
// ----------------------------------------------------------------------------
// jaap_pkg
// Types, constants and helpers for the joint angle acceleration predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package jaap_pkg;

    localparam logic [1:0] OP_MOVE  = 2'd0;
    localparam logic [1:0] OP_BRAKE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [15:0] MS_PER_S = 16'd1000;

    localparam int PROD_W    = 50;   // 33 x 17 signed product
    localparam int MAG_W     = 48;   // product magnitude
    localparam int QUO_W     = 49;   // signed quotient
    localparam int DIV_STEPS = 4;    // quotient bits per cycle
    localparam int DIV_ITERS = MAG_W / DIV_STEPS;
    localparam int CNT_W     = $clog2(DIV_ITERS);

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] measured_angle;
        logic [15:0]        elapsed_ms;
        logic signed [31:0] accel_command;
    } jaap_in_t;

    typedef struct packed {
        logic signed [31:0] target_angle;
        logic signed [31:0] speed;
    } jaap_out_t;

    // request to the multiply-divide unit: q = a * b / d, truncated toward zero
    typedef struct packed {
        logic               start;
        logic signed [32:0] a;
        logic [15:0]        b;
        logic [15:0]        d;
    } mdu_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [QUO_W-1:0]  q;
    } mdu_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v[PROD_W-1:31] == {(PROD_W-31){v[PROD_W-1]}})
            r = v[31:0];
        else if (v[PROD_W-1])
            r = Q_MIN;
        else
            r = Q_MAX;
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/jaap_mdu.sv]
// ----------------------------------------------------------------------------
// jaap_mdu
// Shared multiply-divide unit: registered signed multiply, then a restoring
// divide of the product magnitude, four quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jaap_mdu (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire jaap_pkg::mdu_req_t req,
    output jaap_pkg::mdu_rsp_t     rsp
);
    import jaap_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_FIN} mdu_state_t;

    mdu_state_t               state_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [MAG_W-1:0]         dvd_reg;
    logic [15:0]              rem_reg;
    logic [15:0]              d_reg;
    logic                     neg_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [QUO_W-1:0]  q_reg;
    logic                     done_reg;

    logic signed [16:0]       b_s;
    logic signed [PROD_W-1:0] prod_c;
    logic [PROD_W-1:0]        mag_c;
    logic [MAG_W-1:0]         dvd_c;
    logic [15:0]              rem_c;
    logic [16:0]              sh_c;

    assign b_s    = $signed({1'b0, req.b});
    assign prod_c = req.a * b_s;
    assign mag_c  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

    always_comb
    begin
        rem_c = rem_reg;
        dvd_c = dvd_reg;
        sh_c  = '0;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            sh_c  = {rem_c, dvd_c[MAG_W-1]};
            dvd_c = {dvd_c[MAG_W-2:0], 1'b0};
            if (sh_c >= {1'b0, d_reg})
            begin
                sh_c     = sh_c - {1'b0, d_reg};
                dvd_c[0] = 1'b1;
            end
            rem_c = sh_c[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        prod_reg  <= prod_c;
                        d_reg     <= req.d;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    neg_reg   <= prod_reg[PROD_W-1];
                    dvd_reg   <= mag_c[MAG_W-1:0];
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    dvd_reg <= dvd_c;
                    rem_reg <= rem_c;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_ITERS - 1))
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    q_reg     <= neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

endmodule

`default_nettype wire

[hdl/joint_angle_accel_predictor.sv]
// ----------------------------------------------------------------------------
// joint_angle_accel_predictor
// Speed estimate with stored acceleration and angle prediction, Q16.16.
// ----------------------------------------------------------------------------
// A move or brake request makes three passes through one shared
// multiply-divide unit (angle change x 1000 / ms, stored accel x ms / 1000,
// speed x ms / 1000), each a 48-bit divide at four quotient bits per cycle.
// A zero elapsed_ms skips the first two passes, a zero speed skips the
// last. A clear or an unused operation code gives no result. in_ready is
// low while a request is in work; a finished result waits in the output
// register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module joint_angle_accel_predictor (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire jaap_pkg::jaap_in_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output jaap_pkg::jaap_out_t     out_data
);
    import jaap_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_RAW, S_CHG, S_SPD, S_TSTART, S_TGT, S_DONE
    } seq_state_t;

    seq_state_t              state_reg;
    logic signed [31:0]      prev_reg;
    logic signed [31:0]      stored_reg;
    logic [1:0]              op_reg;
    logic signed [31:0]      meas_reg;
    logic [15:0]             t_reg;
    logic signed [31:0]      cmd_reg;
    logic signed [31:0]      raw_reg;
    logic signed [QUO_W-1:0] chg_reg;
    logic signed [31:0]      spd_reg;
    logic signed [31:0]      tgt_reg;
    mdu_req_t                req_reg;
    logic                    out_valid_reg;
    jaap_out_t               out_data_reg;

    mdu_rsp_t                rsp;

    logic signed [PROD_W-1:0] sum_c;
    logic signed [PROD_W-1:0] tgt_sum_c;
    logic signed [PROD_W-1:0] q_ext;
    logic [32:0]              raw_mag_c;
    logic [QUO_W-1:0]         chg_mag_c;
    logic signed [31:0]       spd_c;
    logic signed [31:0]       cmd_neg_c;
    logic signed [31:0]       brake_acc_c;
    logic                     raw_pos_c;

    jaap_mdu u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_reg),
        .rsp   (rsp)
    );

    assign q_ext     = {rsp.q[QUO_W-1], rsp.q};
    assign sum_c     = {{(PROD_W-32){raw_reg[31]}}, raw_reg} + {chg_reg[QUO_W-1], chg_reg};
    assign tgt_sum_c = {{(PROD_W-32){meas_reg[31]}}, meas_reg} + q_ext;
    assign raw_mag_c = raw_reg[31] ? -{1'b1, raw_reg} : {1'b0, raw_reg};
    assign chg_mag_c = chg_reg[QUO_W-1] ? QUO_W'(-chg_reg) : QUO_W'(chg_reg);
    assign raw_pos_c = !raw_reg[31] && (raw_reg != 32'sd0);
    assign cmd_neg_c = -cmd_reg;

    always_comb
    begin
        if (stored_reg == 32'sd0)
            spd_c = raw_reg;
        else if (op_reg == OP_MOVE)
            spd_c = sat32(sum_c);
        else if (chg_mag_c < QUO_W'(raw_mag_c))
            spd_c = sat32(sum_c);
        else
            spd_c = 32'sd0;
    end

    // brake: magnitude of the command, signed against the raw speed
    always_comb
    begin
        if (raw_pos_c)
            brake_acc_c = cmd_reg[31] ? cmd_reg : cmd_neg_c;
        else if (cmd_reg == Q_MIN)
            brake_acc_c = Q_MAX;
        else
            brake_acc_c = cmd_reg[31] ? cmd_neg_c : cmd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_reg      <= '0;
            stored_reg    <= '0;
            req_reg.start <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_reg.start <= 1'b0;
            if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        unique case (in_data.operation)
                            OP_CLEAR:
                                stored_reg <= '0;
                            OP_MOVE, OP_BRAKE:
                            begin
                                op_reg   <= in_data.operation;
                                meas_reg <= in_data.measured_angle;
                                t_reg    <= in_data.elapsed_ms;
                                cmd_reg  <= in_data.accel_command;
                                if (in_data.elapsed_ms == 16'd0)
                                begin
                                    raw_reg   <= '0;
                                    chg_reg   <= '0;
                                    state_reg <= S_SPD;
                                end
                                else
                                begin
                                    req_reg.start <= 1'b1;
                                    req_reg.a     <= {in_data.measured_angle[31],
                                                      in_data.measured_angle}
                                                     - {prev_reg[31], prev_reg};
                                    req_reg.b     <= MS_PER_S;
                                    req_reg.d     <= in_data.elapsed_ms;
                                    state_reg     <= S_RAW;
                                end
                            end
                            default:
                                ;
                        endcase
                    end
                end
                S_RAW:
                begin
                    if (rsp.done)
                    begin
                        raw_reg       <= sat32(q_ext);
                        req_reg.start <= 1'b1;
                        req_reg.a     <= {stored_reg[31], stored_reg};
                        req_reg.b     <= t_reg;
                        req_reg.d     <= MS_PER_S;
                        state_reg     <= S_CHG;
                    end
                end
                S_CHG:
                begin
                    if (rsp.done)
                    begin
                        chg_reg   <= rsp.q;
                        state_reg <= S_SPD;
                    end
                end
                S_SPD:
                begin
                    spd_reg    <= spd_c;
                    prev_reg   <= meas_reg;
                    stored_reg <= (op_reg == OP_MOVE) ? cmd_reg : brake_acc_c;
                    state_reg  <= S_TSTART;
                end
                S_TSTART:
                begin
                    if (spd_reg == 32'sd0)
                    begin
                        tgt_reg   <= meas_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        req_reg.start <= 1'b1;
                        req_reg.a     <= {spd_reg[31], spd_reg};
                        req_reg.b     <= t_reg;
                        req_reg.d     <= MS_PER_S;
                        state_reg     <= S_TGT;
                    end
                end
                S_TGT:
                begin
                    if (rsp.done)
                    begin
                        tgt_reg   <= sat32(tgt_sum_c);
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_data_reg.target_angle <= tgt_reg;
                        out_data_reg.speed        <= spd_reg;
                        out_valid_reg             <= 1'b1;
                        state_reg                 <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

[hdl/jaap_checker.sv]
// ----------------------------------------------------------------------------
// jaap_port_checks
// Port-level checks for the joint angle acceleration predictor.
// ----------------------------------------------------------------------------
`default_nettype none

`include "joint_angle_accel_predictor_defines.svh"

module jaap_port_checks (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire jaap_pkg::jaap_in_t  in_data,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire jaap_pkg::jaap_out_t out_data
);
    import jaap_pkg::*;

    logic req_work;
    logic req_clear;
    logic busy;
    logic out_stall;

    assign req_work  = in_valid && in_ready &&
                       (in_data.operation == OP_MOVE || in_data.operation == OP_BRAKE);
    assign req_clear = in_valid && in_ready && (in_data.operation == OP_CLEAR);
    assign busy      = !in_ready;
    assign out_stall = out_valid && !out_ready;

    `JAAP_ASSERT_NXT(a_busy_after_work, req_work, busy ##1 busy ##1 busy, "ready too soon")
    `JAAP_ASSERT_NXT(a_clear_no_result, req_clear, !busy && !$rose(out_valid), "bad clear")
    `JAAP_ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(busy), "result without work")
    `JAAP_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_data), "result changed")

endmodule

bind joint_angle_accel_predictor jaap_port_checks u_jaap_port_checks (.*);

`default_nettype wire

[tb/sv/jaap_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jaap_checker
// Watches both channels of the joint angle predictor. Every accepted
// request is run through a local Q16.16 speed and angle predictor. The
// predicted target angle and speed go into an in-order queue. Every
// accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module jaap_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  jaap_pkg::jaap_in_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  jaap_pkg::jaap_out_t out_data,
    output int                  fail_count,
    output int                  awaiting,
    output int                  results_checked
);
    import jaap_pkg::*;

    localparam longint MS = longint'(MS_PER_S);

    logic signed [31:0] last_angle = '0;
    logic signed [31:0] held_accel = '0;
    jaap_out_t          predicted_q[$];
    int                 err_count = 0;
    int                 seen      = 0;

    function automatic longint clamp32(longint v);
        if (v > longint'(Q_MAX))
            return longint'(Q_MAX);
        if (v < longint'(Q_MIN))
            return longint'(Q_MIN);
        return v;
    endfunction

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic predict(jaap_in_t r);
        longint    ang;
        longint    dt;
        longint    raw;
        longint    change;
        longint    spd;
        longint    tgt;
        jaap_out_t p;
        ang = longint'($signed(r.measured_angle));
        dt  = longint'(r.elapsed_ms);
        case (r.operation)
            OP_CLEAR: held_accel = '0;
            OP_MOVE, OP_BRAKE:
            begin
                raw = (dt == 0) ? 0 : clamp32((ang - longint'(last_angle)) * MS / dt);
                change = longint'(held_accel) * dt / MS;
                spd = raw;
                if (held_accel != 0)
                begin
                    if (r.operation == OP_MOVE || abs64(change) < abs64(raw))
                        spd = clamp32(raw + change);
                    else
                        spd = 0;
                end
                tgt = (spd == 0) ? ang : clamp32(ang + spd * dt / MS);
                last_angle = r.measured_angle;
                if (r.operation == OP_MOVE)
                    held_accel = r.accel_command;
                else
                    held_accel = 32'(clamp32((raw > 0)
                        ? -abs64(longint'($signed(r.accel_command)))
                        :  abs64(longint'($signed(r.accel_command)))));
                p.target_angle = tgt[31:0];
                p.speed        = spd[31:0];
                predicted_q.push_back(p);
            end
            default: ;
        endcase
    endtask

    task automatic check_result(jaap_out_t got);
        jaap_out_t want;
        seen++;
        if (predicted_q.size() == 0)
        begin
            err_count++;
            $display("%0t: unexpected result target_angle %h speed %h",
                     $time, got.target_angle, got.speed);
        end
        else
        begin
            want = predicted_q.pop_front();
            if (got.target_angle !== want.target_angle)
            begin
                err_count++;
                $display("%0t: target_angle expected %h actual %h",
                         $time, want.target_angle, got.target_angle);
            end
            if (got.speed !== want.speed)
            begin
                err_count++;
                $display("%0t: speed expected %h actual %h",
                         $time, want.speed, got.speed);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_angle = '0;
            held_accel = '0;
            predicted_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (in_valid && in_ready)
                predict(in_data);
        end
        fail_count      <= err_count;
        awaiting        <= predicted_q.size();
        results_checked <= seen;
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the joint angle acceleration predictor. A short
// directed list covers the field extremes and the zero-time, brake-to-zero,
// clear and unused-code cases. Random trajectories with noise follow. The
// sender runs in random bursts and the receiver stalls in changing patterns.
// The jaap_checker instance does all of the checking.
// ----------------------------------------------------------------------------
module testbench;
    import jaap_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_COUNT = 450;
    localparam int         SETTLE       = 100;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    jaap_in_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    jaap_out_t out_data;

    int fail_count;
    int awaiting;
    int results_checked;

    int                 burst_left = 1;
    int                 gap        = 0;
    int                 stall_left = 0;
    int                 ready_pct  = 100;
    logic signed [31:0] traj_angle = '0;
    int                 n_move     = 0;
    int                 n_brake    = 0;
    int                 n_clear    = 0;
    int                 n_unused   = 0;

    joint_angle_accel_predictor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    jaap_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .fail_count      (fail_count),
        .awaiting        (awaiting),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout: results still awaited: %0d", awaiting);
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: stall density is picked anew from four levels when stall_left runs out
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_left = $urandom_range(32, 256);
                case ($urandom_range(0, 3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 75;
                    2:       ready_pct = 35;
                    default: ready_pct = 8;
                endcase
            end
            stall_left--;
            out_ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    function automatic jaap_in_t mk(logic [1:0] op, logic signed [31:0] ang,
                                    logic [15:0] ms, logic signed [31:0] acc);
        jaap_in_t r;
        r.operation      = op;
        r.measured_angle = ang;
        r.elapsed_ms     = ms;
        r.accel_command  = acc;
        return r;
    endfunction

    function automatic jaap_in_t random_request();
        jaap_in_t r;
        int       pick;
        pick = $urandom_range(0, 99);
        r.operation = (pick < 45) ? OP_MOVE : (pick < 85) ? OP_BRAKE :
                      (pick < 95) ? OP_CLEAR : OP_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            r.measured_angle = traj_angle + int'($urandom_range(0, 2097152)) - 1048576;
        else if (pick < 90)
            r.measured_angle = $urandom;
        else
            case ($urandom_range(0, 2))
                0:       r.measured_angle = Q_MAX;
                1:       r.measured_angle = Q_MIN;
                default: r.measured_angle = '0;
            endcase
        pick = $urandom_range(0, 99);
        if (pick < 10)
            r.elapsed_ms = '0;
        else if (pick < 20)
            r.elapsed_ms = 16'($urandom_range(0, 65535));
        else if (pick < 25)
            r.elapsed_ms = 16'hffff;
        else
            r.elapsed_ms = 16'($urandom_range(1, 250));
        pick = $urandom_range(0, 99);
        if (pick < 60)
            r.accel_command = int'($urandom_range(0, 8388608)) - 4194304;
        else if (pick < 85)
            r.accel_command = $urandom;
        else
            case ($urandom_range(0, 2))
                0:       r.accel_command = Q_MAX;
                1:       r.accel_command = Q_MIN;
                default: r.accel_command = '0;
            endcase
        return r;
    endfunction

    task automatic send(jaap_in_t r);
        case (r.operation)
            OP_MOVE:  n_move++;
            OP_BRAKE: n_brake++;
            OP_CLEAR: n_clear++;
            default:  n_unused++;
        endcase
        if (r.operation == OP_MOVE || r.operation == OP_BRAKE)
            traj_angle = r.measured_angle;
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // hold off until every predicted result has been seen
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (awaiting != 0);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(mk(OP_MOVE,  32'sh0000_0000, 16'd0,     32'sh0000_0000));
        send(mk(OP_MOVE,  32'sh000a_0000, 16'd100,   32'sh0005_0000));
        send(mk(OP_MOVE,  32'sh000c_8000, 16'd50,    Q_MIN));
        send(mk(OP_MOVE,  Q_MAX,          16'd1,     Q_MAX));
        send(mk(OP_MOVE,  Q_MIN,          16'd1,     Q_MIN));
        send(mk(OP_BRAKE, Q_MIN,          16'd0,     Q_MIN));
        send(mk(OP_BRAKE, Q_MIN,          16'd100,   32'sh0001_0000));
        send(mk(OP_BRAKE, 32'sh0010_0000, 16'd1000,  32'sh0000_4000));
        send(mk(OP_BRAKE, 32'sh0012_0000, 16'd10,    32'sh7000_0000));
        send(mk(OP_BRAKE, 32'sh0012_0100, 16'hffff,  32'sh0000_0100));
        send(mk(OP_CLEAR, 32'sh1234_5678, 16'hffff,  Q_MAX));
        send(mk(OP_MOVE,  32'sh0013_0000, 16'd20,    32'shffff_0000));
        send(mk(OP_UNUSED, Q_MAX,         16'hffff,  Q_MIN));
        send(mk(OP_MOVE,  32'sh0014_0000, 16'hffff,  Q_MAX));
        send(mk(OP_MOVE,  32'shfff0_0000, 16'h8000,  Q_MIN));
        send(mk(OP_BRAKE, 32'shffe0_0000, 16'h0001,  Q_MIN));
        send(mk(OP_BRAKE, 32'shffe0_0000, 16'h0200,  32'sh0000_0001));
        send(mk(OP_MOVE,  32'sh0000_0001, 16'h5555,  32'sh5555_5555));
        send(mk(OP_MOVE,  32'shaaaa_aaaa, 16'haaaa,  32'shaaaa_aaaa));
        send(mk(OP_CLEAR, 32'sh0000_0000, 16'd0,     32'sh0000_0000));
        send(mk(OP_BRAKE, 32'shaaaa_0000, 16'd0,     32'sh0000_0000));
        drain();

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            send(random_request());
            if (i == RANDOM_COUNT / 3 || i == 2 * RANDOM_COUNT / 3)
                drain();
        end
        drain();
        repeat (SETTLE) @(posedge clk);

        $display("Requests: %0d move, %0d brake, %0d clear, %0d unused code",
                 n_move, n_brake, n_clear, n_unused);
        $display("Results compared: %0d, mismatches: %0d", results_checked, fail_count);
        if (fail_count == 0 && awaiting == 0)
            $display("*** PASSED ***");
        else
        begin
            if (awaiting != 0)
                $display("Results never delivered: %0d", awaiting);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
